FILE: rtl/gfra_pkg.sv
package gfra_pkg;

    localparam int LANES      = 4;
    localparam int A_W        = 16;
    localparam int PROD_W     = 2 * A_W;
    localparam int ACC_W      = 48;
    localparam int IN_DATA_W  = (LANES + 1) * A_W + LANES * ACC_W;
    localparam int OUT_DATA_W = LANES * ACC_W;
    localparam int X_LSB      = LANES * A_W;
    localparam int PRIOR_LSB  = X_LSB + A_W;
    localparam int MODE_W     = 2;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [MODE_W-1:0] MODE_STORE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUB   = 2'd2;

    // One classified column on its way to the accumulators
    typedef struct packed {
        logic                              last;
        logic [LANES-1:0][ACC_W-1:0]       prior;
        logic [LANES-1:0][PROD_W-1:0]      prod;
    } entry_t;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic head_valid;
    } queue_status_t;

endpackage

FILE: rtl/gfra_front.sv
module gfra_front (
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [gfra_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    input  gfra_pkg::queue_status_t          q_status,
    output logic                             push,
    output gfra_pkg::entry_t                 push_entry
);

    logic signed [gfra_pkg::A_W-1:0] x_val;

    assign x_val    = $signed(s_tdata[gfra_pkg::X_LSB +: gfra_pkg::A_W]);
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && !q_status.full;

    always_comb
    begin
        logic signed [gfra_pkg::A_W-1:0]    a_val;
        logic signed [gfra_pkg::PROD_W-1:0] p;
        push_entry.last = s_tlast;
        for (int i = 0; i < gfra_pkg::LANES; i++)
        begin
            a_val = $signed(s_tdata[i*gfra_pkg::A_W +: gfra_pkg::A_W]);
            p     = a_val * x_val;
            push_entry.prod[i]  = p;
            push_entry.prior[i] =
                s_tdata[gfra_pkg::PRIOR_LSB + i*gfra_pkg::ACC_W +: gfra_pkg::ACC_W];
        end
    end

endmodule

FILE: rtl/gfra_queue.sv
module gfra_queue #(
    parameter int QUEUE_DEPTH = gfra_pkg::QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  gfra_pkg::entry_t        push_entry,
    input  logic                    pop,
    output gfra_pkg::queue_status_t q_status,
    output gfra_pkg::entry_t        head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    gfra_pkg::entry_t entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign q_status.full       = (count_reg == FULL_CNT);
    assign q_status.head_valid = (count_reg != '0);
    assign head                = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/gfra_back.sv
module gfra_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [gfra_pkg::MODE_W-1:0]      update_mode,
    input  gfra_pkg::queue_status_t          q_status,
    input  gfra_pkg::entry_t                 head,
    output logic                             pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [gfra_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [0:0]                       m_tuser
);

    localparam int LANES = gfra_pkg::LANES;
    localparam int ACC_W = gfra_pkg::ACC_W;

    function automatic logic [ACC_W-1:0] clip48(input logic [ACC_W:0] v);
        logic [ACC_W-1:0] r;
        if (v[ACC_W] != v[ACC_W-1])
        begin
            r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

    logic [LANES-1:0][ACC_W-1:0] acc_reg, acc_next;
    logic                        clip_reg, clip_next;

    logic [LANES-1:0][ACC_W-1:0] fin_sum_reg, fin_prior_reg;
    logic                        fin_clip_reg;
    logic                        fin_valid_reg, fin_valid_next;

    logic [gfra_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                            out_sat_reg;
    logic                            out_valid_reg, out_valid_next;

    logic [LANES-1:0][ACC_W-1:0] sat_sum;
    logic                        acc_clip;
    logic [LANES-1:0][ACC_W-1:0] result;
    logic                        res_clip;
    logic                        fin_adv, fin_ready, out_load;

    assign fin_adv   = !out_valid_reg || m_tready;
    assign fin_ready = !fin_valid_reg || fin_adv;
    assign pop       = q_status.head_valid && (!head.last || fin_ready);
    assign out_load  = fin_valid_reg && fin_adv;

    // Accumulate with clipping at the 48-bit limits
    always_comb
    begin
        logic [ACC_W:0] wide;
        acc_clip = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            wide = {acc_reg[i][ACC_W-1], acc_reg[i]}
                 + {{(ACC_W+1-gfra_pkg::PROD_W){head.prod[i][gfra_pkg::PROD_W-1]}},
                    head.prod[i]};
            sat_sum[i] = clip48(wide);
            acc_clip   = acc_clip | (wide[ACC_W] != wide[ACC_W-1]);
        end
    end

    always_comb
    begin
        acc_next       = acc_reg;
        clip_next      = clip_reg;
        fin_valid_next = fin_valid_reg;
        if (out_load)
        begin
            fin_valid_next = 1'b0;
        end
        if (pop)
        begin
            if (head.last)
            begin
                acc_next       = '0;
                clip_next      = 1'b0;
                fin_valid_next = 1'b1;
            end
            else
            begin
                acc_next  = sat_sum;
                clip_next = clip_reg | acc_clip;
            end
        end
    end

    // Merge with prior y; unused mode code behaves as subtract
    always_comb
    begin
        logic [ACC_W:0] wide;
        res_clip = fin_clip_reg;
        for (int i = 0; i < LANES; i++)
        begin
            case (update_mode)
                gfra_pkg::MODE_STORE:
                begin
                    wide = {fin_sum_reg[i][ACC_W-1], fin_sum_reg[i]};
                end
                gfra_pkg::MODE_ADD:
                begin
                    wide = {fin_prior_reg[i][ACC_W-1], fin_prior_reg[i]}
                         + {fin_sum_reg[i][ACC_W-1], fin_sum_reg[i]};
                end
                default:
                begin
                    wide = {fin_prior_reg[i][ACC_W-1], fin_prior_reg[i]}
                         - {fin_sum_reg[i][ACC_W-1], fin_sum_reg[i]};
                end
            endcase
            result[i] = clip48(wide);
            res_clip  = res_clip | (wide[ACC_W] != wide[ACC_W-1]);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            clip_reg      <= 1'b0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            clip_reg      <= clip_next;
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
        begin
            fin_sum_reg   <= sat_sum;
            fin_prior_reg <= head.prior;
            fin_clip_reg  <= clip_reg | acc_clip;
        end
        if (out_load)
        begin
            out_data_reg <= result;
            out_sat_reg  <= res_clip;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_sat_reg;

endmodule

FILE: rtl/gemv_four_row_accumulate.sv
// Four-row slice of y = A*x in fixed point. Each request on the slave side is one
// matrix column: four Q1.15 entries and one Q1.15 vector element; the four lanes
// multiply exactly and add into 48-bit Q18.30 accumulators that clip at the limits.
// The request with tlast high ends the run and produces one result on the master
// side: the sums, prior y plus the sums, or prior y minus the sums, per update_mode
// (code 3 subtracts), each clipped to 48 bits, with tuser set if anything clipped
// in the run or in the final merge. One column is taken every cycle while the queue
// is not full. The products are written into the queue as a column is taken; the
// last column's sums pass into the final-sum registers as it leaves the queue, and
// the merge with prior y is loaded into the output register. The products are
// computed on entry to a short queue, so the input keeps flowing while a result
// waits on the master side until the queue fills. update_mode may only be
// written while no run is in progress.
module gemv_four_row_accumulate #(
    parameter int QUEUE_DEPTH = gfra_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gfra_pkg::MODE_W-1:0]      cfg_wdata,   // update_mode
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // a_row0, a_row1, a_row2, a_row3, x_value, y_prior_0..y_prior_3
    input  logic [gfra_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,     // is_last
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // y_out_0, y_out_1, y_out_2, y_out_3
    output logic [gfra_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [0:0]                       m_tuser      // saturated
);

    logic [gfra_pkg::MODE_W-1:0] mode_reg, mode_next;

    gfra_pkg::queue_status_t q_status;
    gfra_pkg::entry_t        push_entry;
    gfra_pkg::entry_t        head;
    logic                    push;
    logic                    pop;

    assign mode_next = cfg_we ? cfg_wdata : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= gfra_pkg::MODE_STORE;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    gfra_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    gfra_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_status   (q_status),
        .head       (head)
    );

    gfra_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .update_mode (mode_reg),
        .q_status    (q_status),
        .head        (head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

FILE: rtl/gfra_checker.sv
module gfra_checker #(
    parameter int QUEUE_DEPTH = gfra_pkg::QUEUE_DEPTH
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_we,
    input logic [gfra_pkg::MODE_W-1:0]      cfg_wdata,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [gfra_pkg::IN_DATA_W-1:0]   s_tdata,
    input logic                             s_tlast,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [gfra_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [0:0]                       m_tuser
);

    localparam int MAX_PEND = QUEUE_DEPTH + 2;
    localparam int PEND_W   = $clog2(MAX_PEND + 2);

    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              last_in, res_out;

    assign last_in = s_tvalid && s_tready && s_tlast;
    assign res_out = m_tvalid && m_tready;

    // Count runs closed on the input but not yet delivered
    always_comb
    begin
        pend_next = pend_reg;
        if (last_in && !res_out)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (res_out && !last_in && pend_reg != '0)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != '0)
        else $error("result without a closed run");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PEND_W'(MAX_PEND))
        else $error("too many runs pending");

    a_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == PEND_W'(MAX_PEND) |-> !s_tready || !m_tvalid || m_tready)
        else $error("input taken with pipeline full");

endmodule

bind gemv_four_row_accumulate gfra_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_gfra_checker (.*);
